[rtl/square_wave_beep_generator_macros.svh]
// ============================================================================
// Beep generator assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ============================================================================
`ifndef SQUARE_WAVE_BEEP_GENERATOR_MACROS_SVH
`define SQUARE_WAVE_BEEP_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

`define SQB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("beep generator check failed");

`define SQB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("beep generator check failed");

`else

`define SQB_ASSERT_IMPL(lbl, ante, cons)

`define SQB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/sqbeep_pkg.sv]
// ============================================================================
// Beep generator package
// Widths, constants, sequencer states and inter-module bundles.
// ============================================================================
package sqbeep_pkg;

    localparam int FIELD_W    = 16;
    localparam int SAMPLE_W   = 14;
    localparam int PHASE_W    = 16;
    localparam int DIVIDEND_W = 32;
    localparam int COUNT_W    = 23;
    localparam int RECIP_W    = 29;
    localparam int RECIP_SHIFT = 38;

    localparam logic [FIELD_W-1:0]         DEFAULT_RATE  = 16'd16000;
    localparam logic [FIELD_W-1:0]         MS_PER_S      = 16'd1000;
    localparam logic [RECIP_W-1:0]         RECIP_MS      = 29'd274877907;
    localparam logic signed [SAMPLE_W-1:0] AMPLITUDE     = 14'sd6000;
    localparam logic signed [SAMPLE_W-1:0] NEG_AMPLITUDE = -14'sd6000;
    localparam logic signed [SAMPLE_W-1:0] SILENCE       = 14'sd0;

    typedef enum logic
    {
        OP_QUEUE = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed
    {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [FIELD_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed
    {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed
    {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       active;
    } res_t;

endpackage

[rtl/sqbeep_div.sv]
// ============================================================================
// Beep generator divider
// Restoring divider, one quotient bit per cycle, a 32-bit quotient per request.
// ============================================================================
module sqbeep_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sqbeep_pkg::div_req_t req,
    output sqbeep_pkg::div_rsp_t rsp
);
    import sqbeep_pkg::*;

    localparam int STEPS = DIVIDEND_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [FIELD_W-1:0]    rem_reg;
    logic [FIELD_W-1:0]    dvs_reg;

    logic [FIELD_W:0]      trial;
    logic [FIELD_W:0]      diff;
    logic                  fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/sqbeep_ctrl.sv]
// ============================================================================
// Beep generator sequencer
// Command decode, beep state and sequencing of the divider.
// ============================================================================
`include "square_wave_beep_generator_macros.svh"

module sqbeep_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                cmd,
    input  logic [sqbeep_pkg::FIELD_W-1:0]      tone_hz,
    input  logic [sqbeep_pkg::FIELD_W-1:0]      duration_ms,
    input  logic [sqbeep_pkg::FIELD_W-1:0]      rate,
    output logic                                in_ready,
    output sqbeep_pkg::res_t                    res,
    input  logic                                res_take,
    output sqbeep_pkg::div_req_t                div_req,
    input  sqbeep_pkg::div_rsp_t                div_rsp
);
    import sqbeep_pkg::*;

    state_t                     state_reg;
    state_t                     state_next;
    op_t                        op_reg;
    op_t                        op_next;
    logic [FIELD_W-1:0]         freq_reg;
    logic [FIELD_W-1:0]         freq_next;
    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         count_next;
    logic [PHASE_W-1:0]         phase_reg;
    logic [PHASE_W-1:0]         phase_next;
    logic [DIVIDEND_W-1:0]      dvd_reg;
    logic [DIVIDEND_W-1:0]      dvd_next;
    logic [FIELD_W-1:0]         dvs_reg;
    logic [FIELD_W-1:0]         dvs_next;
    logic signed [SAMPLE_W-1:0] pend_sample_reg;
    logic signed [SAMPLE_W-1:0] pend_sample_next;
    logic                       pend_active_reg;
    logic                       pend_active_next;

    logic                       accept;
    logic                       is_tick;
    logic                       queue_empty;
    logic                       count_zero;
    logic                       tick_done;
    logic                       queue_scale;
    logic [DIVIDEND_W+RECIP_W-1:0] recip_prod;
    logic [COUNT_W-1:0]         scaled;

    assign accept      = in_valid && (state_reg == ST_IDLE);
    assign is_tick     = (op_t'(cmd) == OP_TICK);
    assign queue_empty = (tone_hz == '0) || (duration_ms == '0);
    assign count_zero  = (count_reg == '0);
    assign tick_done   = (state_reg == ST_WAIT) && div_rsp.done && (op_reg == OP_TICK);
    assign queue_scale = (state_reg == ST_START) && (op_reg == OP_QUEUE);
    assign recip_prod  = dvd_reg * RECIP_MS;
    assign scaled      = recip_prod[RECIP_SHIFT+COUNT_W-1:RECIP_SHIFT];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_tick)
                        state_next = count_zero ? ST_OUT : ST_START;
                    else if (!queue_empty)
                        state_next = ST_START;
                end
            end
            ST_START:
                state_next = (op_reg == OP_TICK) ? ST_WAIT : ST_IDLE;
            ST_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res_take)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = (state_reg == ST_IDLE);
        div_req.start    = (state_reg == ST_START) && (op_reg == OP_TICK);
        div_req.dividend = dvd_reg;
        div_req.divisor  = dvs_reg;
        res.valid        = (state_reg == ST_OUT);
        res.sample       = pend_sample_reg;
        res.active       = pend_active_reg;
    end

    always_comb
    begin
        op_next          = op_reg;
        freq_next        = freq_reg;
        count_next       = count_reg;
        phase_next       = phase_reg;
        dvd_next         = dvd_reg;
        dvs_next         = dvs_reg;
        pend_sample_next = pend_sample_reg;
        pend_active_next = pend_active_reg;
        if (accept)
        begin
            op_next = op_t'(cmd);
            if (is_tick)
            begin
                dvd_next         = {freq_reg, {(DIVIDEND_W - FIELD_W){1'b0}}};
                dvs_next         = rate;
                pend_active_next = !count_zero;
                if (count_zero)
                    pend_sample_next = SILENCE;
                else
                    pend_sample_next = phase_reg[PHASE_W-1] ? AMPLITUDE : NEG_AMPLITUDE;
            end
            else if (queue_empty)
            begin
                count_next = '0;
            end
            else
            begin
                freq_next = tone_hz;
                dvd_next  = DIVIDEND_W'(duration_ms) * DIVIDEND_W'(rate);
            end
        end
        else if (queue_scale)
        begin
            if (scaled == '0)
                count_next = COUNT_W'(1);
            else
                count_next = scaled;
        end
        else if (tick_done)
        begin
            phase_next = phase_reg + div_rsp.quotient[PHASE_W-1:0];
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_QUEUE;
            freq_reg  <= '0;
            count_reg <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            freq_reg  <= freq_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg         <= dvd_next;
        dvs_reg         <= dvs_next;
        pend_sample_reg <= pend_sample_next;
        pend_active_reg <= pend_active_next;
    end

    `SQB_ASSERT_IMPL(a_done_in_wait, div_rsp.done, state_reg == ST_WAIT)
    `SQB_ASSERT_NEXT(a_tick_starts_div, accept && is_tick && !count_zero, state_reg == ST_START)
    `SQB_ASSERT_NEXT(a_tick_drops_count, tick_done, count_reg == $past(count_reg) - COUNT_W'(1))
    `SQB_ASSERT_NEXT(a_phase_holds, (state_reg == ST_WAIT) && !div_rsp.done, $stable(phase_reg))

endmodule

[rtl/square_wave_beep_generator.sv]
// A sample request passes through the start, wait and output states to out_valid;
// a silent one goes straight from idle to the output state. A non-empty queue request
// passes through the start state before the next request is taken; it gives no result.
// One request at a time: a sample request holds the input until its result is taken.
// Reset: rst_n clears phase, frequency and count, and sets the rate register to 16000.
// ============================================================================
// Square wave beep generator
// Top level: rate register, output register, sequencer and divider.
// ============================================================================
module square_wave_beep_generator
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [sqbeep_pkg::FIELD_W-1:0]          sample_rate,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    cmd,
    input  logic [sqbeep_pkg::FIELD_W-1:0]          tone_hz,
    input  logic [sqbeep_pkg::FIELD_W-1:0]          duration_ms,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [sqbeep_pkg::SAMPLE_W-1:0]  sample,
    output logic                                    active
);
    import sqbeep_pkg::*;

    logic [FIELD_W-1:0]         rate_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       active_reg;

    logic                       in_ready;
    res_t                       res;
    logic                       res_take;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    assign cfg_ready = 1'b1;
    assign in_stall  = !in_ready;
    assign res_take  = res.valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_reg <= DEFAULT_RATE;
        else if (cfg_valid && cfg_ready)
            rate_reg <= (sample_rate == '0) ? DEFAULT_RATE : sample_rate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            sample_reg <= res.sample;
            active_reg <= res.active;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign active    = active_reg;

    sqbeep_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .cmd         (cmd),
        .tone_hz     (tone_hz),
        .duration_ms (duration_ms),
        .rate        (rate_reg),
        .in_ready    (in_ready),
        .res         (res),
        .res_take    (res_take),
        .div_req     (div_req),
        .div_rsp     (div_rsp)
    );

    sqbeep_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule
